[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Assertion that is ignored while reset is applied.
`define RMF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that is checked at every clock edge, reset included.
`define RMF_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMF_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define RMF_ASSERT(lbl, clk, prop, msg)
`endif
`endif

[rtl/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// Recursive median filter package
// Sizes, word types and sequencer states of the recursive median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

  // Sample format and window limits.
  localparam int SAMPLE_BITS = 24;
  localparam int MAX_WINDOW  = 15;
  localparam int HIST_DEPTH  = MAX_WINDOW / 2;
  localparam int LOOK_DEPTH  = MAX_WINDOW - MAX_WINDOW / 2;

  // Derived widths.
  localparam int CFG_W   = 8;
  localparam int WS_W    = $clog2(MAX_WINDOW + 1);
  localparam int CAND_W  = $clog2(MAX_WINDOW);
  localparam int RANK_W  = $clog2(MAX_WINDOW + 1);
  localparam int PEND_W  = $clog2(LOOK_DEPTH + 1);
  localparam int LOOK_AW = $clog2(LOOK_DEPTH);

  // Window sizes below this value pass samples through unfiltered.
  localparam logic [CFG_W-1:0] BYPASS_BELOW = CFG_W'(3);
  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(5);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    block_end;
  } in_word_t;

  typedef struct packed {
    sample_t filtered;
    logic    last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RANK,
    ST_EMIT,
    ST_BYPASS
  } state_t;

endpackage

`default_nettype wire

[rtl/recursive_median_filter_top.sv]
// ----------------------------------------------------------------------------
// Recursive median filter
// Rank-select median over past outputs and raw lookahead samples.
// ----------------------------------------------------------------------------
// One input word is taken at a time; in_stall stays high until every result
// it causes has been loaded into the output register. An item that gives no
// result passes from the check state back to idle. Each median result is
// found by a rank scan and then loaded, because a single rank unit tests one
// window candidate per cycle against all window entries. In bypass every
// pending sample and then the new sample are loaded in turn. A stall on the
// output holds the sequencer until the output register is free. The user
// must write the window size register only while the block is idle, which
// the block itself does not enforce; it takes effect on the next word.
`default_nettype none

`include "assert_macros.svh"

module recursive_median_filter_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rmf_pkg::in_word_t           in_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rmf_pkg::out_word_t               out_word,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rmf_pkg::CFG_W-1:0]   cfg_wr_data
);

  // Registers.
  rmf_pkg::state_t                  state_r, state_nxt;
  logic [rmf_pkg::CFG_W-1:0]        cfg_window_r;
  logic [rmf_pkg::PEND_W-1:0]       pend_r, pend_nxt;
  rmf_pkg::sample_t                 hist_r [rmf_pkg::HIST_DEPTH];
  rmf_pkg::sample_t                 hist_nxt [rmf_pkg::HIST_DEPTH];
  rmf_pkg::sample_t                 look_r [rmf_pkg::LOOK_DEPTH];
  rmf_pkg::sample_t                 look_nxt [rmf_pkg::LOOK_DEPTH];
  rmf_pkg::sample_t                 last_raw_r, last_raw_nxt;
  logic                             end_r, end_nxt;
  logic [rmf_pkg::CAND_W-1:0]       cand_r, cand_nxt;
  rmf_pkg::sample_t                 med_r, med_nxt;
  logic                             out_valid_r, out_valid_nxt;
  rmf_pkg::out_word_t               out_word_r, out_word_nxt;

  // Window geometry.
  logic                             bypass;
  logic [rmf_pkg::WS_W-1:0]         win_len;
  logic [rmf_pkg::WS_W-1:0]         half;
  logic [rmf_pkg::WS_W-1:0]         look_len;

  // Window and rank unit.
  rmf_pkg::sample_t                 win [rmf_pkg::MAX_WINDOW];
  logic [rmf_pkg::MAX_WINDOW-1:0]   win_vld;
  rmf_pkg::sample_t                 cand_val;
  logic [rmf_pkg::MAX_WINDOW-1:0]   lt_vec, le_vec;
  logic [rmf_pkg::RANK_W-1:0]       lt_cnt, le_cnt;
  logic                             rank_hit;

  // Sequencing helpers.
  logic                             in_acc;
  logic                             out_free;
  logic                             need_emit;
  logic                             more_after;
  logic [rmf_pkg::PEND_W-1:0]       pend_dec;

  // Effective window: clamp to the maximum, detect bypass.
  always_comb begin
    bypass  = cfg_window_r < rmf_pkg::BYPASS_BELOW;
    if (cfg_window_r > rmf_pkg::CFG_W'(rmf_pkg::MAX_WINDOW)) begin
      win_len = rmf_pkg::WS_W'(rmf_pkg::MAX_WINDOW);
    end else begin
      win_len = cfg_window_r[rmf_pkg::WS_W-1:0];
    end
    half     = win_len >> 1;
    look_len = win_len - half - rmf_pkg::WS_W'(1);
  end

  // Window slots: history entries first, then the lookahead entries. A
  // lookahead slot past the pending samples repeats the newest raw sample.
  always_comb begin
    for (int s = 0; s < rmf_pkg::HIST_DEPTH; s++) begin
      win[s]     = hist_r[s];
      win_vld[s] = rmf_pkg::WS_W'(s) < half;
    end
    for (int k = 0; k < rmf_pkg::LOOK_DEPTH; k++) begin
      win[rmf_pkg::HIST_DEPTH + k]     = (rmf_pkg::PEND_W'(k) < pend_r) ? look_r[k]
                                                                        : last_raw_r;
      win_vld[rmf_pkg::HIST_DEPTH + k] = rmf_pkg::WS_W'(k) <= look_len;
    end
  end

  // Rank unit: count window entries below and not above the candidate.
  always_comb begin
    cand_val = win[cand_r];
    for (int j = 0; j < rmf_pkg::MAX_WINDOW; j++) begin
      lt_vec[j] = win_vld[j] && (win[j] < cand_val);
      le_vec[j] = win_vld[j] && (win[j] <= cand_val);
    end
    lt_cnt   = rmf_pkg::RANK_W'($countones(lt_vec));
    le_cnt   = rmf_pkg::RANK_W'($countones(le_vec));
    rank_hit = win_vld[cand_r] && (lt_cnt <= rmf_pkg::RANK_W'(half))
               && (rmf_pkg::RANK_W'(half) < le_cnt);
  end

  // Handshake and loop conditions.
  always_comb begin
    in_acc     = in_valid && (state_r == rmf_pkg::ST_IDLE);
    out_free   = !out_valid_r || !out_stall;
    pend_dec   = pend_r - rmf_pkg::PEND_W'(1);
    need_emit  = (pend_r > rmf_pkg::PEND_W'(look_len)) || (end_r && (pend_r != '0));
    more_after = (pend_dec > rmf_pkg::PEND_W'(look_len)) || (end_r && (pend_dec != '0));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bypass ? rmf_pkg::ST_BYPASS : rmf_pkg::ST_CHECK;
        end
      end
      rmf_pkg::ST_CHECK: begin
        state_nxt = need_emit ? rmf_pkg::ST_RANK : rmf_pkg::ST_IDLE;
      end
      rmf_pkg::ST_RANK: begin
        if (rank_hit) begin
          state_nxt = rmf_pkg::ST_EMIT;
        end
      end
      rmf_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = more_after ? rmf_pkg::ST_RANK : rmf_pkg::ST_IDLE;
        end
      end
      rmf_pkg::ST_BYPASS: begin
        if (out_free && (pend_r == '0)) begin
          state_nxt = rmf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rmf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    pend_nxt      = pend_r;
    hist_nxt      = hist_r;
    look_nxt      = look_r;
    last_raw_nxt  = last_raw_r;
    end_nxt       = end_r;
    cand_nxt      = cand_r;
    med_nxt       = med_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      rmf_pkg::ST_IDLE: begin
        if (in_acc) begin
          last_raw_nxt = in_word.sample;
          end_nxt      = in_word.block_end;
          if (!bypass) begin
            look_nxt[pend_r[rmf_pkg::LOOK_AW-1:0]] = in_word.sample;
            pend_nxt = pend_r + rmf_pkg::PEND_W'(1);
          end
        end
      end
      rmf_pkg::ST_CHECK: begin
        cand_nxt = '0;
      end
      rmf_pkg::ST_RANK: begin
        if (rank_hit) begin
          med_nxt = cand_val;
        end else if (cand_r == rmf_pkg::CAND_W'(rmf_pkg::MAX_WINDOW - 1)) begin
          cand_nxt = '0;
        end else begin
          cand_nxt = cand_r + rmf_pkg::CAND_W'(1);
        end
      end
      rmf_pkg::ST_EMIT: begin
        // Load the median, push it into the history, retire the oldest sample.
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.filtered    = med_r;
          out_word_nxt.last_of_run = !more_after;
          for (int k = rmf_pkg::HIST_DEPTH - 1; k > 0; k--) begin
            hist_nxt[k] = hist_r[k-1];
          end
          hist_nxt[0] = med_r;
          for (int k = 0; k < rmf_pkg::LOOK_DEPTH - 1; k++) begin
            look_nxt[k] = look_r[k+1];
          end
          pend_nxt = pend_dec;
          cand_nxt = '0;
        end
      end
      rmf_pkg::ST_BYPASS: begin
        // Flush pending samples in order, then the new sample.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_r != '0) begin
            out_word_nxt.filtered    = look_r[0];
            out_word_nxt.last_of_run = 1'b0;
            for (int k = 0; k < rmf_pkg::LOOK_DEPTH - 1; k++) begin
              look_nxt[k] = look_r[k+1];
            end
            pend_nxt = pend_dec;
          end else begin
            out_word_nxt.filtered    = last_raw_r;
            out_word_nxt.last_of_run = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rmf_pkg::ST_IDLE;
      cfg_window_r <= rmf_pkg::WINDOW_RESET;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
      cand_r       <= '0;
      for (int k = 0; k < rmf_pkg::HIST_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cand_r      <= cand_nxt;
      hist_r      <= hist_nxt;
      if (cfg_wr_en) begin
        cfg_window_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    look_r     <= look_nxt;
    last_raw_r <= last_raw_nxt;
    end_r      <= end_nxt;
    med_r      <= med_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != rmf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Reset leaves the sequencer idle with an empty output register.
  `RMF_ASSERT(a_reset_idle, clk, !rst_n |=> (state_r == rmf_pkg::ST_IDLE && !out_valid_r), "reset did not idle the block")
  // Between words no more samples wait than the largest lookahead.
  `RMF_ASSERT_RST(a_pend_bound, clk, rst_n, (state_r == rmf_pkg::ST_IDLE) |-> (pend_r < rmf_pkg::PEND_W'(rmf_pkg::LOOK_DEPTH)), "too many pending samples while idle")
  // The rank scan always finds the median before it runs out of candidates.
  `RMF_ASSERT_RST(a_rank_found, clk, rst_n, (state_r == rmf_pkg::ST_RANK && cand_r == rmf_pkg::CAND_W'(rmf_pkg::MAX_WINDOW - 1)) |-> rank_hit, "no window entry ranked as median")
  // A result waits while the output register is full and stalled.
  `RMF_ASSERT_RST(a_emit_hold, clk, rst_n, (state_r == rmf_pkg::ST_EMIT && out_valid_r && out_stall) |=> (state_r == rmf_pkg::ST_EMIT), "median left before output register freed")

endmodule

`default_nettype wire
